// ===== rtl/core/entry_list_fnv1a64_signature_assert.svh =====
// ----------------------------------------------------------------------------
// Entry-list signature assertion macros
// Shared concurrent assertion forms used by the signature block.
// ----------------------------------------------------------------------------
`ifndef ENTRY_LIST_FNV1A64_SIGNATURE_ASSERT_SVH
`define ENTRY_LIST_FNV1A64_SIGNATURE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ELSIG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("elsig: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ELSIG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("elsig: next-cycle check failed");

`endif

// ===== rtl/core/elsig_pkg.sv =====
// ----------------------------------------------------------------------------
// Entry-list signature package
// Operation codes, hash constants, and the control word shared by the
// sequencer and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package elsig_pkg;

	// Operation codes of an input transaction.
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_PATH  = 2'd1;
	localparam logic [1:0] OP_END   = 2'd2;

	// FNV-1a 64 constants. The prime is 2^40 + 2^8 + 0xb3.
	localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

	// Byte source selects of the fold unit.
	localparam logic [1:0] BSEL_ZERO = 2'd0;
	localparam logic [1:0] BSEL_HEX  = 2'd1;
	localparam logic [1:0] BSEL_DEC  = 2'd2;
	localparam logic [1:0] BSEL_NL   = 2'd3;

	// Jump conditions of a control word.
	localparam logic [1:0] JMP_NONE = 2'd0;
	localparam logic [1:0] JMP_CNT  = 2'd1;
	localparam logic [1:0] JMP_BIT  = 2'd2;
	localparam logic [1:0] JMP_POW  = 2'd3;

	localparam int UPC_W = 3;
	typedef logic [UPC_W-1:0] upc_t;

	// One control word of the microprogram.
	typedef struct packed {
		logic       fold;
		logic [1:0] bsel;
		logic       hex_init;
		logic       hex_shift;
		logic       dec_init;
		logic       div_step;
		logic       dec_emit;
		logic [1:0] jmp;
		upc_t       target;
		logic       last;
	} ucode_t;

	// Loop status returned by the datapath for conditional jumps.
	typedef struct packed {
		logic cnt_nz;
		logic bit_nz;
		logic pow_nz;
	} dp_flags_t;

endpackage

// ===== rtl/core/entry_list_fnv1a64_signature.sv =====
// ----------------------------------------------------------------------------
// Entry-list FNV-1a 64 signature
// Running 64-bit FNV-1a hash over path bytes and entry trailers.
// ----------------------------------------------------------------------------
// Every input transaction returns one signature. Start, path byte and unused
// operation codes finish in the acceptance cycle; the result then waits in
// the pending stage until the output register is free, and no new transaction
// is taken until it has moved on. An end-of-entry transaction runs a 61-step
// microprogram on the single byte fold unit: one NUL, eight hex digits, one
// NUL, then ten decimal places of four restoring divide steps plus one fold
// step each, and the newline.
// Entries must arrive already sorted by path.
`timescale 1ns / 1ps
`include "entry_list_fnv1a64_signature_assert.svh"

module entry_list_fnv1a64_signature (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  path_byte,
	input  logic [31:0] entry_crc,
	input  logic [31:0] entry_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] signature
);
	import elsig_pkg::*;

	ucode_t      uw;
	dp_flags_t   flags;
	logic        run;
	logic        done;
	logic        acc;
	logic        start;
	logic [63:0] hash;
	logic        pend_q;
	logic        out_valid_q;
	logic [63:0] signature_q;
	logic        slot_free;

	// A transaction is taken only when no item is in flight.
	assign in_ready  = ~run & ~pend_q;
	assign acc       = in_valid & in_ready;
	assign start     = acc & (operation == OP_END);
	assign slot_free = ~out_valid_q | out_ready;

	elsig_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.uw     (uw),
		.run    (run),
		.done   (done)
	);

	elsig_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc          (acc),
		.operation    (operation),
		.path_byte    (path_byte),
		.entry_crc    (entry_crc),
		.entry_length (entry_length),
		.uw           (uw),
		.flags        (flags),
		.hash         (hash)
	);

	// A finished item waits here until the output register is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if ((acc && operation != OP_END) || done) begin
			pend_q <= 1'b1;
		end else if (pend_q && slot_free) begin
			pend_q <= 1'b0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_q && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q && slot_free) begin
			signature_q <= hash;
		end
	end

	assign out_valid = out_valid_q;
	assign signature = signature_q;

	// Checks on sequencing and result hand-off.
	`ELSIG_ASSERT_NXT(a_end_runs_program, clk, arst_n, start, run && !pend_q)
	`ELSIG_ASSERT_NXT(a_short_op_pends, clk, arst_n, acc && operation != OP_END, pend_q && !run)
	`ELSIG_ASSERT_NXT(a_result_loads, clk, arst_n, pend_q && slot_free, out_valid && signature == $past(hash))
	`ELSIG_ASSERT_IMP(a_run_excl_pend, clk, arst_n, run, !pend_q)

endmodule

// ===== rtl/core/elsig_useq.sv =====
// ----------------------------------------------------------------------------
// Entry-list signature microsequencer
// Step counter and control store that run the end-of-entry program.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elsig_useq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  elsig_pkg::dp_flags_t flags,
	output elsig_pkg::ucode_t   uw,
	output logic                run,
	output logic                done
);
	import elsig_pkg::*;

	// Program addresses.
	localparam upc_t U_HEAD = 3'd0;
	localparam upc_t U_HEX  = 3'd1;
	localparam upc_t U_SEP  = 3'd2;
	localparam upc_t U_DIV  = 3'd3;
	localparam upc_t U_EMIT = 3'd4;
	localparam upc_t U_NL   = 3'd5;

	logic   run_q;
	upc_t   pc_q;
	ucode_t rom_w;
	logic   taken;

	// Control store: NUL, eight hex digits, NUL, ten decimal digits, newline.
	always_comb begin
		rom_w = '0;
		unique case (pc_q)
			U_HEAD: begin
				rom_w.fold     = 1'b1;
				rom_w.bsel     = BSEL_ZERO;
				rom_w.hex_init = 1'b1;
			end
			U_HEX: begin
				rom_w.fold      = 1'b1;
				rom_w.bsel      = BSEL_HEX;
				rom_w.hex_shift = 1'b1;
				rom_w.jmp       = JMP_CNT;
				rom_w.target    = U_HEX;
			end
			U_SEP: begin
				rom_w.fold     = 1'b1;
				rom_w.bsel     = BSEL_ZERO;
				rom_w.dec_init = 1'b1;
			end
			U_DIV: begin
				rom_w.div_step = 1'b1;
				rom_w.jmp      = JMP_BIT;
				rom_w.target   = U_DIV;
			end
			U_EMIT: begin
				rom_w.fold     = 1'b1;
				rom_w.bsel     = BSEL_DEC;
				rom_w.dec_emit = 1'b1;
				rom_w.jmp      = JMP_POW;
				rom_w.target   = U_DIV;
			end
			U_NL: begin
				rom_w.fold = 1'b1;
				rom_w.bsel = BSEL_NL;
				rom_w.last = 1'b1;
			end
			default: rom_w = '0;
		endcase
	end

	// The word only acts while the program runs.
	assign uw   = run_q ? rom_w : '0;
	assign run  = run_q;
	assign done = run_q & rom_w.last;

	// Conditional jump evaluation.
	always_comb begin
		case (rom_w.jmp)
			JMP_CNT: taken = flags.cnt_nz;
			JMP_BIT: taken = flags.bit_nz;
			JMP_POW: taken = flags.pow_nz;
			default: taken = 1'b0;
		endcase
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			pc_q  <= U_HEAD;
		end else if (start) begin
			run_q <= 1'b1;
			pc_q  <= U_HEAD;
		end else if (run_q) begin
			if (rom_w.last) begin
				run_q <= 1'b0;
				pc_q  <= U_HEAD;
			end else if (taken) begin
				pc_q <= rom_w.target;
			end else begin
				pc_q <= pc_q + upc_t'(1);
			end
		end
	end

endmodule

// ===== rtl/core/elsig_dpath.sv =====
// ----------------------------------------------------------------------------
// Entry-list signature datapath
// Running hash with its byte fold unit, hex digit shifter and a restoring
// decimal digit extractor driven by the control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elsig_dpath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 acc,
	input  logic [1:0]           operation,
	input  logic [7:0]           path_byte,
	input  logic [31:0]          entry_crc,
	input  logic [31:0]          entry_length,
	input  elsig_pkg::ucode_t    uw,
	output elsig_pkg::dp_flags_t flags,
	output logic [63:0]          hash
);
	import elsig_pkg::*;

	logic [63:0] hash_q;
	logic [63:0] hash_d;
	logic [31:0] crc_q;
	logic [31:0] rem_q;
	logic [2:0]  cnt_q;
	logic [1:0]  bit_q;
	logic [3:0]  pow_q;
	logic [3:0]  dig_q;
	logic        started_q;

	logic [7:0]  fold_byte;
	logic        emit_ok;
	logic        fold_go;
	logic [35:0] div_sub;
	logic        div_ge;

	// One FNV-1a round: xor the byte in, then multiply by the prime as
	// shifted copies (2^40 + 2^8 + 0x80 + 0x20 + 0x10 + 0x2 + 0x1).
	function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		begin
			x = h ^ {56'd0, b};
			fnv_fold = (x << 40) + (x << 8) + (x << 7) + (x << 5)
				+ (x << 4) + (x << 1) + x;
		end
	endfunction

	// Decimal place values.
	function automatic logic [31:0] pow10(input logic [3:0] k);
		begin
			case (k)
				4'd0:    pow10 = 32'd1;
				4'd1:    pow10 = 32'd10;
				4'd2:    pow10 = 32'd100;
				4'd3:    pow10 = 32'd1000;
				4'd4:    pow10 = 32'd10000;
				4'd5:    pow10 = 32'd100000;
				4'd6:    pow10 = 32'd1000000;
				4'd7:    pow10 = 32'd10000000;
				4'd8:    pow10 = 32'd100000000;
				4'd9:    pow10 = 32'd1000000000;
				default: pow10 = 32'd0;
			endcase
		end
	endfunction

	// Lowercase hex ASCII of one nibble.
	function automatic logic [7:0] hex_ascii(input logic [3:0] n);
		begin
			hex_ascii = (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h57 + {4'd0, n});
		end
	endfunction

	// Byte source of the fold unit.
	always_comb begin
		case (uw.bsel)
			BSEL_ZERO: fold_byte = 8'h00;
			BSEL_HEX:  fold_byte = hex_ascii(crc_q[31:28]);
			BSEL_DEC:  fold_byte = 8'h30 + {4'd0, dig_q};
			default:   fold_byte = 8'h0a;
		endcase
	end

	// Leading zeros are skipped, but the units digit always goes out.
	assign emit_ok = (dig_q != 4'd0) | started_q | (pow_q == 4'd0);
	assign fold_go = uw.fold & ((uw.bsel != BSEL_DEC) | emit_ok);

	// One restoring step of the digit quotient for the current place.
	assign div_sub = {4'd0, pow10(pow_q)} << bit_q;
	assign div_ge  = {4'd0, rem_q} >= div_sub;

	// Next hash value.
	always_comb begin
		hash_d = hash_q;
		if (acc) begin
			case (operation)
				OP_START: hash_d = FNV_BASIS;
				OP_PATH:  hash_d = fnv_fold(hash_q, path_byte);
				default:  hash_d = hash_q;
			endcase
		end else if (fold_go) begin
			hash_d = fnv_fold(hash_q, fold_byte);
		end
	end

	// Running hash.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= FNV_BASIS;
		end else begin
			hash_q <= hash_d;
		end
	end

	// Working registers of the end-of-entry program.
	always_ff @(posedge clk) begin
		if (acc && operation == OP_END) begin
			crc_q <= entry_crc;
			rem_q <= entry_length;
		end
		if (uw.hex_init) begin
			cnt_q <= 3'd7;
		end
		if (uw.hex_shift) begin
			crc_q <= {crc_q[27:0], 4'd0};
			cnt_q <= cnt_q - 3'd1;
		end
		if (uw.dec_init) begin
			pow_q     <= 4'd9;
			bit_q     <= 2'd3;
			dig_q     <= 4'd0;
			started_q <= 1'b0;
		end
		if (uw.div_step) begin
			bit_q <= bit_q - 2'd1;
			if (div_ge) begin
				rem_q        <= rem_q - div_sub[31:0];
				dig_q[bit_q] <= 1'b1;
			end
		end
		if (uw.dec_emit) begin
			pow_q <= pow_q - 4'd1;
			bit_q <= 2'd3;
			dig_q <= 4'd0;
			if (emit_ok) begin
				started_q <= 1'b1;
			end
		end
	end

	assign flags.cnt_nz = (cnt_q != 3'd0);
	assign flags.bit_nz = (bit_q != 2'd0);
	assign flags.pow_nz = (pow_q != 4'd0);
	assign hash         = hash_q;

endmodule

// ===== test/tb_entry_list_fnv1a64_signature.sv =====
// ----------------------------------------------------------------------------
// Entry-list signature testbench
// Drives start, path byte, end-of-entry and unused-code transactions into the
// block with random gaps and output stalls. A behavioral FNV-1a 64 predictor
// tracks the running hash and every returned signature is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_entry_list_fnv1a64_signature;
	import elsig_pkg::*;

	// Spare operation code: the hash is returned unchanged.
	localparam logic [1:0]  OP_SPARE       = 2'd3;
	localparam logic [63:0] FNV_PRIME      = 64'd1099511628211;
	localparam int          HOLD_CYCLES    = 300;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          DRAIN_CYCLES   = 80;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic [7:0]  path_byte;
	logic [31:0] entry_crc;
	logic [31:0] entry_length;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] signature;

	logic [63:0] model_hash = FNV_BASIS;
	// Predicted signatures in acceptance order, kept in a ring.
	logic [63:0] want_mem [0:1023];
	logic [9:0]  want_wr_ptr = '0;
	logic [9:0]  want_rd_ptr = '0;
	int          mismatch_count = 0;
	int          quiet_cycles = 0;
	bit          no_gaps = 1'b0;
	bit          hold_request = 1'b0;

	entry_list_fnv1a64_signature u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.path_byte    (path_byte),
		.entry_crc    (entry_crc),
		.entry_length (entry_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.signature    (signature)
	);

	// Clock generation.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// One FNV-1a step over a single byte.
	function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
		return (h ^ {56'd0, b}) * FNV_PRIME;
	endfunction

	// Trailer of an entry: NUL, hex CRC, NUL, decimal size, newline.
	function automatic logic [63:0] fold_trailer(input logic [63:0] h,
			input logic [31:0] crc, input logic [31:0] len);
		logic [63:0] acc;
		logic [3:0]  nib;
		logic [7:0]  dec_chars [0:9];
		logic [31:0] rest;
		logic [31:0] digit;
		int          n;
		int          i;
		acc = fnv_fold(h, 8'h00);
		for (i = 7; i >= 0; i--) begin
			nib = crc[i*4 +: 4];
			if (nib < 4'd10)
				acc = fnv_fold(acc, 8'h30 + {4'h0, nib});
			else
				acc = fnv_fold(acc, 8'h61 + {4'h0, nib - 4'd10});
		end
		acc = fnv_fold(acc, 8'h00);
		// Digits come out least significant first, so fold them in reverse.
		rest = len;
		n = 0;
		do begin
			digit = rest % 32'd10;
			dec_chars[n] = 8'h30 + digit[7:0];
			rest = rest / 32'd10;
			n++;
		end while (rest != 32'd0);
		while (n > 0) begin
			n--;
			acc = fnv_fold(acc, dec_chars[n]);
		end
		return fnv_fold(acc, 8'h0a);
	endfunction

	// Running hash after one transaction.
	function automatic logic [63:0] next_signature(input logic [63:0] h, input logic [1:0] op,
			input logic [7:0] b, input logic [31:0] crc, input logic [31:0] len);
		case (op)
			OP_START: return FNV_BASIS;
			OP_PATH:  return fnv_fold(h, b);
			OP_END:   return fold_trailer(h, crc, len);
			default:  return h;
		endcase
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Present one transaction and wait until it is accepted.
	task automatic offer_item(input logic [1:0] op, input logic [7:0] b,
			input logic [31:0] crc, input logic [31:0] len);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= op;
		path_byte    <= b;
		entry_crc    <= crc;
		entry_length <= len;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Spread of sizes that covers one to ten decimal digits.
	function automatic logic [31:0] pick_length();
		return $urandom >> $urandom_range(0, 31);
	endfunction

	// Reset state is visible through the spare code, then the basis reload.
	task automatic test_reset_and_start();
		offer_item(OP_SPARE, 8'hff, 32'hffff_ffff, 32'hffff_ffff);
		offer_item(OP_START, 8'hff, 32'hffff_ffff, 32'hffff_ffff);
	endtask

	// Path bytes at the extremes, including a zero byte, with junk in unused fields.
	task automatic test_path_bytes();
		offer_item(OP_PATH, 8'h00, 32'hffff_ffff, 32'hffff_ffff);
		offer_item(OP_PATH, 8'hff, 32'h0000_0000, 32'h0000_0000);
		offer_item(OP_PATH, 8'h80, 32'h5555_5555, 32'haaaa_aaaa);
		offer_item(OP_PATH, 8'h01, 32'haaaa_aaaa, 32'h5555_5555);
	endtask

	// Entry trailers: extreme CRCs and sizes, digit-count boundaries, empty path.
	task automatic test_entry_trailers();
		offer_item(OP_END, 8'hff, 32'h0000_0000, 32'd0);
		offer_item(OP_END, 8'h00, 32'hffff_ffff, 32'hffff_ffff);
		offer_item(OP_START, 8'h00, 32'h0, 32'h0);
		offer_item(OP_END, 8'h5a, 32'h0123_abcd, 32'd9);
		offer_item(OP_PATH, 8'h2f, 32'h0, 32'h0);
		offer_item(OP_END, 8'ha5, 32'h89ef_4567, 32'd10);
		offer_item(OP_END, 8'h00, 32'hdead_beef, 32'd1000000000);
		offer_item(OP_END, 8'h00, 32'h8000_0001, 32'd999999999);
		offer_item(OP_SPARE, 8'h3c, 32'h1234_5678, 32'd42);
		offer_item(OP_START, 8'hc3, 32'hffff_ffff, 32'hffff_ffff);
	endtask

	// Back-to-back transactions with no gaps on either side.
	task automatic test_back_to_back();
		int i;
		no_gaps = 1'b1;
		for (i = 0; i < 30; i++) begin
			if (i % 6 == 5)
				offer_item(OP_END, 8'($urandom), $urandom, pick_length());
			else
				offer_item(OP_PATH, 8'($urandom), $urandom, $urandom);
		end
		no_gaps = 1'b0;
	endtask

	// The receiver holds off for a long stretch while transactions keep coming.
	task automatic test_output_backpressure();
		int i;
		hold_request = 1'b1;
		for (i = 0; i < 12; i++) begin
			if (i % 4 == 3)
				offer_item(OP_END, 8'($urandom), $urandom, pick_length());
			else
				offer_item(OP_PATH, 8'($urandom), $urandom, $urandom);
		end
	endtask

	// Well-formed entry lists with random content, mixed with some noise.
	task automatic test_random_entries(input int n_items);
		int          sent;
		int          path_len;
		int          i;
		logic [1:0]  op_junk;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				offer_item(OP_START, 8'($urandom), $urandom, $urandom);
				sent++;
			end
			if ($urandom_range(0, 9) == 0) begin
				op_junk = 2'($urandom_range(0, 3));
				offer_item(op_junk, 8'($urandom), $urandom, pick_length());
				sent++;
			end
			if ($urandom_range(0, 7) == 0)
				path_len = $urandom_range(13, 40);
			else
				path_len = $urandom_range(0, 6);
			for (i = 0; i < path_len; i++) begin
				offer_item(OP_PATH, 8'($urandom), $urandom, $urandom);
				sent++;
			end
			offer_item(OP_END, 8'($urandom), $urandom, pick_length());
			sent++;
		end
	endtask

	// Main sequence.
	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		operation    = OP_START;
		path_byte    = 8'h00;
		entry_crc    = 32'h0;
		entry_length = 32'h0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_and_start();
		test_path_bytes();
		test_entry_trailers();
		test_back_to_back();
		test_output_backpressure();
		test_random_entries(420);

		in_valid <= 1'b0;
		while (want_rd_ptr != want_wr_ptr) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Result receiver: random stalls, plus one long hold-off on request.
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		out_ready  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Predict the signature of each accepted input transaction.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			model_hash = next_signature(model_hash, operation, path_byte, entry_crc,
				entry_length);
			want_mem[want_wr_ptr] = model_hash;
			want_wr_ptr = want_wr_ptr + 10'd1;
		end
	end

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		logic [63:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (want_rd_ptr == want_wr_ptr) begin
				$display("%0t: unexpected signature transaction: expected none, got %h",
					$time, signature);
				mismatch_count++;
			end else begin
				want = want_mem[want_rd_ptr];
				want_rd_ptr = want_rd_ptr + 10'd1;
				if (signature !== want) begin
					$display("%0t: signature mismatch: expected %h, got %h",
						$time, want, signature);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any accepted transaction.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule

// ===== entry_list_fnv1a64_signature.f =====
+incdir+rtl/core
rtl/core/elsig_pkg.sv
rtl/core/elsig_useq.sv
rtl/core/elsig_dpath.sv
rtl/core/entry_list_fnv1a64_signature.sv
test/tb_entry_list_fnv1a64_signature.sv
